/* design/companion_row_l2_distance_unit_defines.svh */
`ifndef COMPANION_ROW_L2_DISTANCE_UNIT_DEFINES_SVH
`define COMPANION_ROW_L2_DISTANCE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define CRL2_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("crl2: same-cycle check failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define CRL2_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("crl2: next-cycle check failed");

`endif

/* design/crl2_pkg.sv */
`default_nettype none

package crl2_pkg;

	localparam int DEF_MAX_WALKERS = 256;
	localparam int DEF_MAX_DIMS    = 64;

	localparam int DIMS_W     = 7;
	localparam int WALKERS_W  = 9;
	localparam int CFG_DATA_W = 9;
	localparam int DIST_W     = 19;
	localparam int SQ_W       = 32;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic CFG_DIMS    = 1'b0;
	localparam logic CFG_WALKERS = 1'b1;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [7:0]         walker_index;
		logic [5:0]         component_index;
		logic signed [15:0] component_value;
		logic [7:0]         companion_index;
	} in_word_t;

	typedef struct packed {
		logic [7:0]        walker_echo;
		logic [DIST_W-1:0] distance;
		logic              status;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_ROOT
	} state_t;

endpackage

`default_nettype wire

/* design/crl2_isqrt.sv */
`default_nettype none

module crl2_isqrt #(
	parameter int SUM_W = 39
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [SUM_W-1:0]         radicand,
	output logic                          done,
	output logic [(SUM_W+1)/2-1:0]        root
);

	localparam int ROOT_W = (SUM_W + 1) / 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);
	localparam logic [SUM_W-1:0] TOP_BIT = SUM_W'(1) << (2 * (ROOT_W - 1));

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] x_q;
	logic [SUM_W-1:0] root_q;
	logic [SUM_W-1:0] bit_q;
	logic [SUM_W:0]   trial;
	logic             take;

	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign take  = {1'b0, x_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			root_q <= '0;
			bit_q  <= TOP_BIT;
		end else if (busy_q) begin
			if (take) begin
				x_q    <= x_q - trial[SUM_W-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[ROOT_W-1:0];

endmodule

`default_nettype wire

/* design/companion_row_l2_distance_unit.sv */
// channel   direction  handshake              word
// cmd       in         start & !busy          crl2_pkg::in_word_t
// result    out        done (one cycle)       crl2_pkg::out_word_t
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// A load writes one store entry at its accept edge when its indices are in range.
// A query in range holds busy through its read, drain and root states after its
// accept edge (with no components it skips the reads) and shows its result in the
// first cycle with busy low: one component pair per cycle from the dual-read store,
// then one bit per cycle in the square-root unit. An out-of-range query never
// raises busy and shows its result in the next cycle.
// Reset clears the control state and sets dims to 1, walkers to 256; the store holds
// garbage until written. The result is shown for one cycle and cannot be stalled.
`default_nettype none

`include "companion_row_l2_distance_unit_defines.svh"

module companion_row_l2_distance_unit #(
	parameter int MAX_WALKERS = crl2_pkg::DEF_MAX_WALKERS,
	parameter int MAX_DIMS    = crl2_pkg::DEF_MAX_DIMS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire crl2_pkg::in_word_t              cmd,
	output logic                                 done,
	output crl2_pkg::out_word_t                  result,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_index,
	input  wire logic [crl2_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH  = MAX_WALKERS * MAX_DIMS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W  = crl2_pkg::SQ_W + $clog2(MAX_DIMS + 1);
	localparam int ROOT_W = (SUM_W + 1) / 2;
	localparam int WL_W   = $clog2(MAX_WALKERS + 1);
	localparam int WCW    = (WL_W > crl2_pkg::WALKERS_W) ? WL_W : crl2_pkg::WALKERS_W;
	localparam int DL_W   = $clog2(MAX_DIMS + 1);
	localparam int DCW    = (DL_W > crl2_pkg::DIMS_W) ? DL_W : crl2_pkg::DIMS_W;
	localparam int CMP_W  = (ROOT_W > crl2_pkg::DIST_W) ? ROOT_W : crl2_pkg::DIST_W;

	logic [15:0] mem [DEPTH];

	crl2_pkg::state_t state_q, state_d;

	logic [crl2_pkg::DIMS_W-1:0]    dims_q;
	logic [crl2_pkg::WALKERS_W-1:0] walkers_q;

	logic                 accept;
	logic                 load_ok;
	logic [AW-1:0]        load_addr;
	logic [WCW-1:0]       limit;
	logic                 out_of_range;
	logic [DCW-1:0]       dims_eff;
	logic                 is_query;
	logic                 issue;
	logic                 last_read;
	logic                 sq_start;
	logic                 sq_done;
	logic [ROOT_W-1:0]    sq_root;
	logic [CMP_W-1:0]     root_wide;
	logic [crl2_pkg::DIST_W-1:0] dist_sat;

	logic [DCW-1:0]       k_q;
	logic [AW-1:0]        addr_a_q;
	logic [AW-1:0]        addr_b_q;
	logic [7:0]           walker_q;
	logic                 v_s1;
	logic [15:0]          rd_a_s1;
	logic [15:0]          rd_b_s1;
	logic                 v_s2;
	logic [crl2_pkg::SQ_W-1:0] prod_s2;
	logic [SUM_W-1:0]     sum_q;
	logic                 done_q;
	crl2_pkg::out_word_t  result_q;

	logic signed [16:0]   diff;
	logic signed [33:0]   diff_sq;

	assign accept   = start && !busy;
	assign is_query = cmd.kind == crl2_pkg::KIND_QUERY;

	assign load_ok = (WCW'(cmd.walker_index) < WCW'(MAX_WALKERS)) &&
		(DCW'(cmd.component_index) < DCW'(MAX_DIMS));
	assign load_addr = AW'(cmd.walker_index) * AW'(MAX_DIMS) + AW'(cmd.component_index);

	assign limit = (WCW'(walkers_q) > WCW'(MAX_WALKERS)) ? WCW'(MAX_WALKERS) : WCW'(walkers_q);
	assign out_of_range = (WCW'(cmd.walker_index) >= limit) ||
		(WCW'(cmd.companion_index) >= limit);
	assign dims_eff = (DCW'(dims_q) > DCW'(MAX_DIMS)) ? DCW'(MAX_DIMS) : DCW'(dims_q);
	assign last_read = (k_q + DCW'(1)) == dims_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q    <= crl2_pkg::DIMS_W'(1);
			walkers_q <= crl2_pkg::WALKERS_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				crl2_pkg::CFG_DIMS: dims_q <= cfg_data[crl2_pkg::DIMS_W-1:0];
				crl2_pkg::CFG_WALKERS: walkers_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_query && load_ok) begin
			mem[load_addr] <= cmd.component_value;
		end
		rd_a_s1 <= mem[addr_a_q];
		rd_b_s1 <= mem[addr_b_q];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			crl2_pkg::ST_IDLE: begin
				if (accept && is_query && !out_of_range) begin
					state_d = (dims_eff == '0) ? crl2_pkg::ST_DRAIN : crl2_pkg::ST_READ;
				end
			end
			crl2_pkg::ST_READ: begin
				if (last_read) begin
					state_d = crl2_pkg::ST_DRAIN;
				end
			end
			crl2_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = crl2_pkg::ST_ROOT;
				end
			end
			crl2_pkg::ST_ROOT: begin
				if (sq_done) begin
					state_d = crl2_pkg::ST_IDLE;
				end
			end
			default: state_d = crl2_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = 1'b1;
		issue    = 1'b0;
		sq_start = 1'b0;
		case (state_q)
			crl2_pkg::ST_IDLE: busy = 1'b0;
			crl2_pkg::ST_READ: issue = 1'b1;
			crl2_pkg::ST_DRAIN: sq_start = !v_s1 && !v_s2;
			crl2_pkg::ST_ROOT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crl2_pkg::ST_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			done_q  <= (accept && is_query && out_of_range) ||
				(state_q == crl2_pkg::ST_ROOT && sq_done);
			if (accept) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + DCW'(1);
			end
		end
	end

	assign diff    = {rd_a_s1[15], rd_a_s1} - {rd_b_s1[15], rd_b_s1};
	assign diff_sq = diff * diff;

	always_ff @(posedge clk) begin
		if (accept) begin
			walker_q <= cmd.walker_index;
			addr_a_q <= AW'(cmd.walker_index) * AW'(MAX_DIMS);
			addr_b_q <= AW'(cmd.companion_index) * AW'(MAX_DIMS);
			sum_q    <= '0;
		end else begin
			if (issue) begin
				addr_a_q <= addr_a_q + AW'(1);
				addr_b_q <= addr_b_q + AW'(1);
			end
			if (v_s2) begin
				sum_q <= sum_q + SUM_W'(prod_s2);
			end
		end
		prod_s2 <= diff_sq[crl2_pkg::SQ_W-1:0];
	end

	crl2_isqrt #(
		.SUM_W(SUM_W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.radicand(sum_q),
		.done    (sq_done),
		.root    (sq_root)
	);

	assign root_wide = CMP_W'(sq_root);
	assign dist_sat  = (root_wide > CMP_W'(crl2_pkg::DIST_MAX)) ?
		crl2_pkg::DIST_MAX : root_wide[crl2_pkg::DIST_W-1:0];

	always_ff @(posedge clk) begin
		if (accept && is_query && out_of_range) begin
			result_q.walker_echo <= cmd.walker_index;
			result_q.distance    <= '0;
			result_q.status      <= crl2_pkg::STATUS_RANGE;
		end else if (state_q == crl2_pkg::ST_ROOT && sq_done) begin
			result_q.walker_echo <= walker_q;
			result_q.distance    <= dist_sat;
			result_q.status      <= crl2_pkg::STATUS_OK;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`CRL2_ASSERT_NOW(a_no_result_mid_sum, clk, arst_n,
		state_q == crl2_pkg::ST_READ || state_q == crl2_pkg::ST_DRAIN, !done_q)
	`CRL2_ASSERT_NOW(a_root_only_in_root, clk, arst_n,
		sq_done, state_q == crl2_pkg::ST_ROOT)
	`CRL2_ASSERT_NOW(a_pipe_empty_in_root, clk, arst_n,
		state_q == crl2_pkg::ST_ROOT, !v_s1 && !v_s2)
	`CRL2_ASSERT_NEXT(a_range_error_next, clk, arst_n,
		accept && is_query && out_of_range,
		done_q && result_q.status == crl2_pkg::STATUS_RANGE && result_q.distance == '0)

endmodule

`default_nettype wire

/* sim/companion_row_l2_distance_unit_tb.sv */
module companion_row_l2_distance_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ROWS         = crl2_pkg::DEF_MAX_WALKERS;
	localparam int N_COLS         = crl2_pkg::DEF_MAX_DIMS;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int N_PHASES       = 9;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            start     = 1'b0;
	logic                            busy;
	crl2_pkg::in_word_t              cmd       = '0;
	logic                            done;
	crl2_pkg::out_word_t             result;
	logic                            cfg_we    = 1'b0;
	logic                            cfg_index = crl2_pkg::CFG_DIMS;
	logic [crl2_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	companion_row_l2_distance_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	crl2_pkg::in_word_t  pending_words[$];
	crl2_pkg::out_word_t expected_results[$];

	logic [crl2_pkg::DIMS_W-1:0]    cfg_dims    = 7'd1;
	logic [crl2_pkg::WALKERS_W-1:0] cfg_walkers = 9'd256;
	logic signed [15:0]    obs_copy [0:N_ROWS*N_COLS-1];

	bit                    loaded_map [0:N_ROWS*N_COLS-1];
	int                    rows_loaded[$];
	int                    items_queued = 0;

	int                    error_count = 0;
	int                    idle_cycles = 0;
	int                    gap_left    = 0;
	int                    calm_left   = 0;

	int phase_dims    [N_PHASES] = '{4, 64, 1, 100, 0, 7, 127, 2, 64};
	int phase_walkers [N_PHASES] = '{256, 256, 16, 300, 40, 1, 511, 200, 2};
	int phase_items   [N_PHASES] = '{250, 300, 150, 250, 100, 100, 200, 200, 150};

	function automatic int eff_dims();
		return (int'(cfg_dims) > N_COLS) ? N_COLS : int'(cfg_dims);
	endfunction

	function automatic int eff_walkers();
		return (int'(cfg_walkers) > N_ROWS) ? N_ROWS : int'(cfg_walkers);
	endfunction

	function automatic crl2_pkg::out_word_t predict_distance(crl2_pkg::in_word_t w);
		crl2_pkg::out_word_t r;
		int               base_a;
		int               base_b;
		int               d;
		longint unsigned  acc;
		longint unsigned  root;
		longint unsigned  trial;
		r.walker_echo = w.walker_index;
		r.distance    = '0;
		r.status      = crl2_pkg::STATUS_RANGE;
		if (int'(w.walker_index) >= eff_walkers() || int'(w.companion_index) >= eff_walkers())
			return r;
		base_a = int'(w.walker_index) * N_COLS;
		base_b = int'(w.companion_index) * N_COLS;
		acc = 0;
		for (int k = 0; k < eff_dims(); k++) begin
			d = int'(obs_copy[base_a + k]) - int'(obs_copy[base_b + k]);
			acc += longint'(d) * longint'(d);
		end
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= acc)
				root = trial;
		end
		if (root > longint'(crl2_pkg::DIST_MAX))
			root = longint'(crl2_pkg::DIST_MAX);
		r.distance = root[crl2_pkg::DIST_W-1:0];
		r.status   = crl2_pkg::STATUS_OK;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
		error_count++;
	endtask

	function automatic logic [15:0] rand_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h7fff;
		if (r == 1)
			return 16'h8000;
		if (r == 2)
			return 16'h0000;
		return 16'($urandom);
	endfunction

	task automatic add_item(logic kind, int walker, int comp, logic [15:0] value, int companion);
		crl2_pkg::in_word_t w;
		w.kind            = kind;
		w.walker_index    = 8'(walker);
		w.component_index = 6'(comp);
		w.component_value = value;
		w.companion_index = 8'(companion);
		pending_words = {pending_words, w};
		if (kind == crl2_pkg::KIND_LOAD)
			loaded_map[walker * N_COLS + comp] = 1'b1;
		items_queued++;
	endtask

	function automatic bit row_ready(int w);
		if (w >= eff_walkers())
			return 1'b0;
		for (int k = 0; k < eff_dims(); k++)
			if (!loaded_map[w * N_COLS + k])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic load_row(int w);
		for (int k = 0; k < eff_dims(); k++)
			add_item(crl2_pkg::KIND_LOAD, w, k, rand_value(), $urandom_range(0, N_ROWS - 1));
		rows_loaded = {rows_loaded, w};
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_words.size() != 0 || start || expected_results.size() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= crl2_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == crl2_pkg::CFG_DIMS)
			cfg_dims = crl2_pkg::DIMS_W'(value);
		else
			cfg_walkers = crl2_pkg::WALKERS_W'(value);
	endtask

	task automatic run_random(int target);
		int first;
		int r;
		int w;
		int c;
		int lim;
		int row_pct;
		bit found;
		first = items_queued;
		while (items_queued - first < target) begin
			lim     = eff_walkers();
			row_pct = (eff_dims() > 16) ? 2 : 12;
			r       = $urandom_range(0, 99);
			if (r < 15) begin
				add_item(crl2_pkg::KIND_LOAD, $urandom_range(0, N_ROWS - 1),
					$urandom_range(0, N_COLS - 1), rand_value(), $urandom_range(0, N_ROWS - 1));
			end else if ((r < 28 || lim == 0) && lim < N_ROWS) begin
				case ($urandom_range(0, 2))
					0: begin
						w = $urandom_range(lim, N_ROWS - 1);
						c = $urandom_range(0, N_ROWS - 1);
					end
					1: begin
						w = $urandom_range(0, N_ROWS - 1);
						c = $urandom_range(lim, N_ROWS - 1);
					end
					default: begin
						w = $urandom_range(lim, N_ROWS - 1);
						c = $urandom_range(lim, N_ROWS - 1);
					end
				endcase
				add_item(crl2_pkg::KIND_QUERY, w, $urandom_range(0, N_COLS - 1), rand_value(), c);
			end else if (r < 28 + row_pct) begin
				load_row($urandom_range(0, lim - 1));
			end else begin
				w = $urandom_range(0, lim - 1);
				c = $urandom_range(0, lim - 1);
				if (eff_dims() > 0) begin
					found = 1'b0;
					for (int t = 0; t < 8 && !found && rows_loaded.size() > 0; t++) begin
						w     = rows_loaded[$urandom_range(0, rows_loaded.size() - 1)];
						c     = rows_loaded[$urandom_range(0, rows_loaded.size() - 1)];
						found = row_ready(w) && row_ready(c);
					end
					if (!found) begin
						w = $urandom_range(0, lim - 1);
						load_row(w);
						if (!row_ready(c))
							c = w;
					end
				end
				add_item(crl2_pkg::KIND_QUERY, w, $urandom_range(0, N_COLS - 1), rand_value(), c);
			end
		end
	endtask

	// hold start while busy, then advance to the next word after a random gap
	always @(posedge clk) begin : driver
		int pick;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				start <= 1'b0;
			end else if (pending_words.size() != 0) begin
				cmd   <= pending_words.pop_front();
				start <= 1'b1;
				if (calm_left > 0) begin
					calm_left = calm_left - 1;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 50)
						gap_left = 0;
					else if (pick < 85)
						gap_left = $urandom_range(1, 3);
					else if (pick < 97)
						gap_left = $urandom_range(4, 15);
					else if (pick == 97)
						calm_left = $urandom_range(40, 120);
					else
						gap_left = $urandom_range(30, 80);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		crl2_pkg::out_word_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result word with none pending, distance", 0, result.distance);
				end else begin
					want = expected_results.pop_front();
					if (result.walker_echo !== want.walker_echo)
						report_mismatch("walker_echo", want.walker_echo, result.walker_echo);
					if (result.distance !== want.distance)
						report_mismatch("distance", want.distance, result.distance);
					if (result.status !== want.status)
						report_mismatch("status", want.status, result.status);
				end
			end
			if (start && !busy) begin
				if (cmd.kind == crl2_pkg::KIND_LOAD)
					obs_copy[int'(cmd.walker_index) * N_COLS + int'(cmd.component_index)] =
						cmd.component_value;
				else
					expected_results = {expected_results, predict_distance(cmd)};
			end
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(crl2_pkg::CFG_DIMS, 1);
		write_reg(crl2_pkg::CFG_WALKERS, 256);
		add_item(crl2_pkg::KIND_LOAD, 0, 0, 16'h7fff, 0);
		add_item(crl2_pkg::KIND_LOAD, 1, 0, 16'h8000, 255);
		add_item(crl2_pkg::KIND_LOAD, 255, 0, 16'h0000, 0);
		add_item(crl2_pkg::KIND_LOAD, 0, 63, rand_value(), 0);
		add_item(crl2_pkg::KIND_QUERY, 0, 0, 16'h0000, 1);
		add_item(crl2_pkg::KIND_QUERY, 1, 63, 16'hffff, 0);
		add_item(crl2_pkg::KIND_QUERY, 0, 0, 16'h0000, 0);
		add_item(crl2_pkg::KIND_QUERY, 255, 0, 16'h0000, 1);
		add_item(crl2_pkg::KIND_QUERY, 1, 0, 16'h0000, 255);
		wait_idle();
		repeat (8) @(posedge clk);

		// index out of range on either side
		write_reg(crl2_pkg::CFG_WALKERS, 3);
		add_item(crl2_pkg::KIND_QUERY, 3, 0, 16'h0000, 0);
		add_item(crl2_pkg::KIND_QUERY, 0, 0, 16'h0000, 3);
		add_item(crl2_pkg::KIND_QUERY, 255, 0, 16'h0000, 255);
		wait_idle();
		repeat (8) @(posedge clk);

		write_reg(crl2_pkg::CFG_WALKERS, 0);
		add_item(crl2_pkg::KIND_QUERY, 0, 0, 16'h0000, 0);
		wait_idle();
		repeat (8) @(posedge clk);

		// empty sum
		write_reg(crl2_pkg::CFG_WALKERS, 256);
		write_reg(crl2_pkg::CFG_DIMS, 0);
		add_item(crl2_pkg::KIND_QUERY, 0, 0, 16'h0000, 1);
		wait_idle();
		repeat (8) @(posedge clk);

		for (int p = 0; p < N_PHASES; p++) begin
			write_reg(crl2_pkg::CFG_DIMS, phase_dims[p]);
			write_reg(crl2_pkg::CFG_WALKERS, phase_walkers[p]);
			run_random(phase_items[p]);
			wait_idle();
			repeat (8) @(posedge clk);
		end

		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* companion_row_l2_distance_unit.f */
+incdir+design
design/crl2_pkg.sv
design/crl2_isqrt.sv
design/companion_row_l2_distance_unit.sv
sim/companion_row_l2_distance_unit_tb.sv
